>>> rtl/chti_pkg.sv
// ----------------------------------------------------------------------------
// chti_pkg
// Shared types and constants for the chained hash table: word formats,
// status codes, sequencer states and the steps of the key mixing hash.
// ----------------------------------------------------------------------------
package chti_pkg;

    localparam int TABLE_SLOTS_DEF = 1024;
    localparam int POOL_NODES_DEF  = 4096;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_EXISTED  = 3'd1;
    localparam logic [2:0] ST_HIT      = 3'd2;
    localparam logic [2:0] ST_MISS     = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam int MIX_SHL_A = 18;
    localparam int MIX_SHR_A = 31;
    localparam logic [4:0] MIX_MUL = 5'd21;
    localparam int MIX_SHR_B = 11;
    localparam int MIX_SHL_B = 6;
    localparam int MIX_SHR_C = 22;

    typedef struct packed {
        logic        operation;
        logic [63:0] key;
        logic [63:0] new_value;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] result_value;
    } out_word_t;

    typedef enum logic [2:0] {
        CTRL_CLEAR,
        CTRL_IDLE,
        CTRL_HASH,
        CTRL_HEAD,
        CTRL_WALK,
        CTRL_DONE
    } ctrl_state_t;

    typedef enum logic [2:0] {
        MIX_NOT_ADD,
        MIX_XOR_A,
        MIX_MULT,
        MIX_XOR_B,
        MIX_ADD_B,
        MIX_XOR_C
    } mix_step_t;

    typedef struct packed {
        logic        start;
        logic [63:0] key;
    } mix_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] hash;
    } mix_rsp_t;

endpackage

>>> rtl/chained_hash_table_insert_lookup.sv
// ----------------------------------------------------------------------------
// chained_hash_table_insert_lookup
// Hash table with separate chaining for 64-bit keys and values: insert or
// lookup per word, chain walk over a node RAM, nodes taken from a fixed pool.
// ----------------------------------------------------------------------------
// s_ready is high only in the idle state, so a new word is taken only after the
// last result is loaded; the six-step hash unit and the one-node-per-cycle walk
// over the node RAM read port set the pace.
// Reset: synchronous; after it a clearing pass writes every bucket head with
// s_ready low.
// ----------------------------------------------------------------------------
module chained_hash_table_insert_lookup #(
    parameter int TABLE_SLOTS = chti_pkg::TABLE_SLOTS_DEF,
    parameter int POOL_NODES  = chti_pkg::POOL_NODES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  chti_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output chti_pkg::out_word_t m_word
);
    import chti_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int NODE_W = $clog2(POOL_NODES);
    localparam int LINK_W = $clog2(POOL_NODES + 1);
    localparam int NODE_MEM_W = 128 + LINK_W;
    localparam logic [SLOT_W-1:0] SLOT_MASK = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [LINK_W-1:0] POOL_LIM  = LINK_W'(POOL_NODES);
    localparam logic [LINK_W-1:0] STEP_LAST = LINK_W'(POOL_NODES - 1);

    ctrl_state_t state_reg, state_next;

    in_word_t          item_reg, item_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] clr_reg, clr_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] steps_reg, steps_next;
    logic [LINK_W-1:0] used_reg, used_next;
    logic              found_reg, found_next;
    logic [63:0]       fval_reg, fval_next;
    logic              m_valid_reg, m_valid_next;
    out_word_t         m_word_reg, m_word_next;

    mix_req_t mix_req;
    mix_rsp_t mix_rsp;
    logic [SLOT_W-1:0] hash_slot;

    logic              bkt_we;
    logic [SLOT_W-1:0] bkt_waddr, bkt_raddr;
    logic [LINK_W-1:0] bkt_wdata, bkt_rdata;

    logic                  node_we;
    logic [NODE_W-1:0]     node_waddr, node_raddr;
    logic [NODE_MEM_W-1:0] node_wdata, node_rdata;
    logic [63:0]           rd_key, rd_val;
    logic [LINK_W-1:0]     rd_link;

    logic accept, out_free, out_load;

    chti_mix u_mix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mix_req),
        .rsp     (mix_rsp)
    );

    chti_ram #(.WIDTH(LINK_W), .DEPTH(TABLE_SLOTS)) u_bkt_ram (
        .aclk  (aclk),
        .we    (bkt_we),
        .waddr (bkt_waddr),
        .wdata (bkt_wdata),
        .raddr (bkt_raddr),
        .rdata (bkt_rdata)
    );

    chti_ram #(.WIDTH(NODE_MEM_W), .DEPTH(POOL_NODES)) u_node_ram (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    assign s_ready   = (state_reg == CTRL_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign hash_slot = mix_rsp.hash[SLOT_W-1:0] & SLOT_MASK;
    assign rd_key    = node_rdata[NODE_MEM_W-1 -: 64];
    assign rd_val    = node_rdata[LINK_W +: 64];
    assign rd_link   = node_rdata[LINK_W-1:0];

    assign mix_req.start = accept;
    assign mix_req.key   = s_word.key;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CTRL_CLEAR: begin
                if (clr_reg == SLOT_LAST) begin
                    state_next = CTRL_IDLE;
                end
            end
            CTRL_IDLE: begin
                if (accept) begin
                    state_next = CTRL_HASH;
                end
            end
            CTRL_HASH: begin
                if (mix_rsp.done) begin
                    state_next = CTRL_HEAD;
                end
            end
            CTRL_HEAD: begin
                if (bkt_rdata == '0 || bkt_rdata > POOL_LIM) begin
                    state_next = CTRL_DONE;
                end else begin
                    state_next = CTRL_WALK;
                end
            end
            CTRL_WALK: begin
                if (rd_key == item_reg.key || rd_link == '0 || rd_link > POOL_LIM
                    || steps_reg == STEP_LAST) begin
                    state_next = CTRL_DONE;
                end
            end
            CTRL_DONE: begin
                if (out_free) begin
                    state_next = CTRL_IDLE;
                end
            end
            default: state_next = CTRL_CLEAR;
        endcase
    end

    always_comb begin
        item_next    = item_reg;
        slot_next    = slot_reg;
        clr_next     = clr_reg;
        head_next    = head_reg;
        steps_next   = steps_reg;
        used_next    = used_reg;
        found_next   = found_reg;
        fval_next    = fval_reg;
        m_word_next  = m_word_reg;
        out_load     = 1'b0;
        bkt_we       = 1'b0;
        bkt_waddr    = slot_reg;
        bkt_wdata    = '0;
        bkt_raddr    = hash_slot;
        node_we      = 1'b0;
        node_waddr   = used_reg[NODE_W-1:0];
        node_wdata   = {item_reg.key, item_reg.new_value, head_reg};
        node_raddr   = '0;
        unique case (state_reg)
            CTRL_CLEAR: begin
                bkt_we    = 1'b1;
                bkt_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
            end
            CTRL_IDLE: begin
                if (accept) begin
                    item_next = s_word;
                end
            end
            CTRL_HASH: begin
                slot_next = hash_slot;
            end
            CTRL_HEAD: begin
                head_next  = bkt_rdata;
                steps_next = '0;
                found_next = 1'b0;
                node_raddr = NODE_W'(bkt_rdata - 1'b1);
            end
            CTRL_WALK: begin
                node_raddr = NODE_W'(rd_link - 1'b1);
                steps_next = steps_reg + 1'b1;
                if (rd_key == item_reg.key) begin
                    found_next = 1'b1;
                    fval_next  = rd_val;
                end
            end
            CTRL_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    m_word_next.result_value = '0;
                    if (item_reg.operation == OP_LOOKUP) begin
                        if (found_reg) begin
                            m_word_next.status       = ST_HIT;
                            m_word_next.result_value = fval_reg;
                        end else begin
                            m_word_next.status = ST_MISS;
                        end
                    end else if (found_reg) begin
                        m_word_next.status       = ST_EXISTED;
                        m_word_next.result_value = fval_reg;
                    end else if (used_reg >= POOL_LIM) begin
                        m_word_next.status = ST_FULL;
                    end else begin
                        m_word_next.status       = ST_INSERTED;
                        m_word_next.result_value = item_reg.new_value;
                        node_we   = 1'b1;
                        bkt_we    = 1'b1;
                        bkt_wdata = used_reg + 1'b1;
                        used_next = used_reg + 1'b1;
                    end
                end
            end
            default: begin
                clr_next = '0;
            end
        endcase
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CTRL_CLEAR;
            clr_reg     <= '0;
            used_reg    <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            used_reg    <= used_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
        item_reg   <= item_next;
        slot_reg   <= slot_next;
        head_reg   <= head_next;
        steps_reg  <= steps_next;
        fval_reg   <= fval_next;
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= POOL_LIM)
        else $error("node pool count past pool size");

    a_node_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        node_we |-> (used_reg < POOL_LIM && state_reg == CTRL_DONE))
        else $error("node written with pool exhausted");

    a_head_with_node: assert property (@(posedge aclk) disable iff (!aresetn)
        (bkt_we && state_reg != CTRL_CLEAR) |-> node_we)
        else $error("bucket head moved without a node write");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwrote a pending word");

    a_accept_hash: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == CTRL_HASH && !mix_rsp.done))
        else $error("accepted word did not start the hash");

endmodule

>>> rtl/chti_ram.sv
// ----------------------------------------------------------------------------
// chti_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module chti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/chti_mix.sv
// ----------------------------------------------------------------------------
// chti_mix
// Iterative 64-to-32 key mixing hash: one shift-and-add, shift-and-xor or multiply
// step per cycle through a single shared datapath, six steps per key.
// ----------------------------------------------------------------------------
module chti_mix (
    input  logic              aclk,
    input  logic              aresetn,
    input  chti_pkg::mix_req_t req,
    output chti_pkg::mix_rsp_t rsp
);
    import chti_pkg::*;

    logic [63:0] k_reg, k_next;
    mix_step_t   step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] alu_out;

    always_comb begin
        unique case (step_reg)
            MIX_NOT_ADD: alu_out = (~k_reg) + (k_reg << MIX_SHL_A);
            MIX_XOR_A:   alu_out = k_reg ^ (k_reg >> MIX_SHR_A);
            MIX_MULT:    alu_out = k_reg * {59'd0, MIX_MUL};
            MIX_XOR_B:   alu_out = k_reg ^ (k_reg >> MIX_SHR_B);
            MIX_ADD_B:   alu_out = k_reg + (k_reg << MIX_SHL_B);
            MIX_XOR_C:   alu_out = k_reg ^ (k_reg >> MIX_SHR_C);
            default:     alu_out = k_reg;
        endcase
    end

    always_comb begin
        k_next    = k_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            k_next    = req.key;
            step_next = MIX_NOT_ADD;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            k_next = alu_out;
            if (step_reg == MIX_XOR_C) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = mix_step_t'(3'(step_reg + 3'd1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= MIX_NOT_ADD;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        k_reg <= k_next;
    end

    assign rsp.done = done_reg;
    assign rsp.hash = k_reg[31:0];

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chained hash table. A short table of inserts and
// lookups covers empty buckets, key and value extremes and chain collisions;
// random traffic with hot buckets builds long chains. Table rows are checked
// against their fixed result words; every other result word is compared
// against a cycle-free model of buckets, node pool and the key mixing hash.
// ----------------------------------------------------------------------------
module tb_top;
    import chti_pkg::*;

    localparam int SLOTS = TABLE_SLOTS_DEF;
    localparam int NODES = POOL_NODES_DEF;
    localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MSB1 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAXP = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        op;
        logic [63:0] key;
        logic [63:0] val;
        logic        mate;
        logic        typed;
        out_word_t   fixed;
    } probe_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    int unsigned bucket_top [SLOTS];
    logic [63:0] pool_key   [NODES];
    logic [63:0] pool_val   [NODES];
    int unsigned pool_next  [NODES];
    int unsigned pool_fill  = 0;
    logic [63:0] stored_keys[$];
    out_word_t   pending_results[$];
    int unsigned hot_slots[4];
    int          mismatches = 0;
    int          words_sent = 0;
    bit          calm       = 1'b0;

    chained_hash_table_insert_lookup uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] mix64_hash(input logic [63:0] k);
        logic [63:0] h;
        h = ~k + (k << MIX_SHL_A);
        h = h ^ (h >> MIX_SHR_A);
        h = h * 64'(MIX_MUL);
        h = h ^ (h >> MIX_SHR_B);
        h = h + (h << MIX_SHL_B);
        h = h ^ (h >> MIX_SHR_C);
        return h[31:0];
    endfunction

    function automatic int unsigned bucket_of(input logic [63:0] k);
        return mix64_hash(k) & (SLOTS - 1);
    endfunction

    function automatic int unsigned chain_find(input int unsigned slot, input logic [63:0] k);
        int unsigned cur;
        int unsigned steps;
        cur   = bucket_top[slot];
        steps = 0;
        while (cur != 0 && steps < NODES) begin
            if (pool_key[cur - 1] == k)
                return cur;
            cur = pool_next[cur - 1];
            steps++;
        end
        return 0;
    endfunction

    function automatic out_word_t table_apply(input in_word_t w);
        out_word_t   r;
        int unsigned slot;
        int unsigned hit;
        int unsigned n;
        slot           = bucket_of(w.key);
        hit            = chain_find(slot, w.key);
        r.result_value = '0;
        if (w.operation == OP_LOOKUP) begin
            r.status = (hit != 0) ? ST_HIT : ST_MISS;
            if (hit != 0)
                r.result_value = pool_val[hit - 1];
        end else if (hit != 0) begin
            r.status       = ST_EXISTED;
            r.result_value = pool_val[hit - 1];
        end else if (pool_fill >= NODES) begin
            r.status = ST_FULL;
        end else begin
            n               = pool_fill;
            pool_key[n]     = w.key;
            pool_val[n]     = w.new_value;
            pool_next[n]    = bucket_top[slot];
            bucket_top[slot] = n + 1;
            pool_fill       = n + 1;
            r.status        = ST_INSERTED;
            r.result_value  = w.new_value;
            stored_keys.push_back(w.key);
        end
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] key_in_slot(input int unsigned slot, input logic [63:0] avoid);
        logic [63:0] k;
        do k = rand64(); while (bucket_of(k) != slot || k == avoid);
        return k;
    endfunction

    function automatic logic [63:0] random_value();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return ALL1;
        return rand64();
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        int       pick;
        pick        = $urandom_range(0, 99);
        w.operation = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_LOOKUP;
        if (pick < 35 && stored_keys.size() > 0)
            w.key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        else if (pick < 65)
            w.key = key_in_slot(hot_slots[$urandom_range(0, 3)], '0);
        else
            w.key = rand64();
        w.new_value = random_value();
        return w;
    endfunction

    function automatic probe_t probe(input logic op, input logic [63:0] k, input logic [63:0] v,
                                     input logic mate, input logic typed,
                                     input logic [2:0] st, input logic [63:0] rv);
        probe_t p;
        p.op    = op;
        p.key   = k;
        p.val   = v;
        p.mate  = mate;
        p.typed = typed;
        p.fixed = '{status: st, result_value: rv};
        return p;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatches < 100)
            $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_word(input in_word_t w, input logic typed, input out_word_t fixed);
        int        gap;
        out_word_t predicted;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_word  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predicted = table_apply(w);
        pending_results.push_back(typed ? fixed : predicted);
        words_sent++;
        if (words_sent % 40 == 0)
            calm = ($urandom_range(0, 3) == 0);
    endtask

    task automatic run_rows(input probe_t rows[$]);
        in_word_t w;
        foreach (rows[i]) begin
            w.operation = rows[i].op;
            w.key       = rows[i].mate ? key_in_slot(bucket_of(rows[i].key), rows[i].key)
                                       : rows[i].key;
            w.new_value = rows[i].val;
            send_word(w, rows[i].typed, rows[i].fixed);
        end
    endtask

    initial begin : result_side
        out_word_t got;
        out_word_t want;
        int        stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = m_word;
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected word: status %0d value %h",
                                        got.status, got.result_value));
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.result_value !== want.result_value)
                    flag_mismatch($sformatf("value %h, want %h",
                                            got.result_value, want.result_value));
            end
        end
    end

    initial begin : stimulus
        probe_t   early[$];
        probe_t   late[$];

        hot_slots[0] = bucket_of('0);
        hot_slots[1] = bucket_of(ALL1);
        hot_slots[2] = $urandom_range(0, SLOTS - 1);
        hot_slots[3] = $urandom_range(0, SLOTS - 1);

        early.push_back(probe(OP_LOOKUP, '0,   '0,   0, 1, ST_MISS,     '0));
        early.push_back(probe(OP_LOOKUP, ALL1, ALL1, 0, 1, ST_MISS,     '0));
        early.push_back(probe(OP_INSERT, '0,   ALL1, 0, 1, ST_INSERTED, ALL1));
        early.push_back(probe(OP_INSERT, '0,   '0,   0, 1, ST_EXISTED,  ALL1));
        early.push_back(probe(OP_LOOKUP, '0,   '0,   0, 1, ST_HIT,      ALL1));
        early.push_back(probe(OP_INSERT, ALL1, '0,   0, 1, ST_INSERTED, '0));
        early.push_back(probe(OP_INSERT, ALL1, ALL1, 0, 1, ST_EXISTED,  '0));
        early.push_back(probe(OP_LOOKUP, ALL1, '0,   0, 1, ST_HIT,      '0));
        early.push_back(probe(OP_INSERT, '0,   64'hA5A5_A5A5_A5A5_A5A5, 1, 0, ST_INSERTED, '0));
        early.push_back(probe(OP_INSERT, '0,   64'h5A5A_5A5A_5A5A_5A5A, 1, 0, ST_INSERTED, '0));
        early.push_back(probe(OP_LOOKUP, '0,   '0,   0, 1, ST_HIT,      ALL1));
        early.push_back(probe(OP_LOOKUP, '0,   '0,   1, 0, ST_MISS,     '0));
        early.push_back(probe(OP_INSERT, '0,   64'h5A5A_5A5A_5A5A_5A5A, 0, 1, ST_EXISTED, ALL1));
        early.push_back(probe(OP_INSERT, ALL1, MSB1 | 64'd1, 1, 0, ST_INSERTED, '0));
        early.push_back(probe(OP_LOOKUP, ALL1, '0,   1, 0, ST_MISS,     '0));
        early.push_back(probe(OP_INSERT, MSB1, 64'd1, 0, 1, ST_INSERTED, 64'd1));
        early.push_back(probe(OP_LOOKUP, MSB1, '0,   0, 1, ST_HIT,      64'd1));
        early.push_back(probe(OP_INSERT, 64'd1, MSB1, 0, 1, ST_INSERTED, MSB1));
        early.push_back(probe(OP_LOOKUP, 64'd1, ALL1, 0, 1, ST_HIT,      MSB1));
        early.push_back(probe(OP_LOOKUP, MAXP, '0,   0, 1, ST_MISS,     '0));
        early.push_back(probe(OP_INSERT, ALL1, 64'hA5A5_A5A5_A5A5_A5A5, 0, 1, ST_EXISTED, '0));

        late.push_back(probe(OP_INSERT, '0,   '0,   0, 1, ST_EXISTED, ALL1));
        late.push_back(probe(OP_LOOKUP, MAXP, '0,   0, 1, ST_MISS,    '0));
        late.push_back(probe(OP_LOOKUP, ALL1, '0,   0, 1, ST_HIT,     '0));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        run_rows(early);
        repeat (500) send_word(random_word(), 1'b0, '0);

        run_rows(late);
        repeat (120) send_word(random_word(), 1'b0, '0);
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
